@@ src/ddodom_pkg.sv @@
// Shared definitions for the differential drive odometry block: widths,
// CORDIC constants, multiplier operand codes and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package ddodom_pkg;

    // CORDIC iteration count, capped at the atan table length
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_N     = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int CNT_W        = (CORDIC_N > 1) ? $clog2(CORDIC_N) : 1;

    // Field and datapath widths
    localparam int CNT_IN_W = 32;   // encoder count
    localparam int MPP_W    = 24;   // Q0.24 metres per pulse
    localparam int GAIN_W   = 32;   // Q16.16 angle units per metre
    localparam int POS_W    = 48;   // Q32.16 positions and travel
    localparam int HEAD_W   = 32;   // binary angle
    localparam int MUL_W    = 33;   // signed multiplier operand
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 82;   // partial product sum
    localparam int CW       = 34;   // CORDIC x/y/z
    localparam int STEP_W   = 50;   // position increment
    localparam int CFG_W    = 32;

    // Rotation start value, gain 0.607252935 in Q2.30
    localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;

    // Configuration register indexes
    localparam logic CFG_MPP  = 1'b0;
    localparam logic CFG_GAIN = 1'b1;

    // Operand pair for the shared multiplier
    typedef enum logic [3:0] {
        MUL_DL = 4'd0,
        MUL_DR = 4'd1,
        MUL_LT = 4'd2,
        MUL_RT = 4'd3,
        MUL_HH = 4'd4,
        MUL_HL = 4'd5,
        MUL_XH = 4'd6,
        MUL_XL = 4'd7,
        MUL_YH = 4'd8,
        MUL_YL = 4'd9
    } mul_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     cap_dl;
        logic     cap_dr;
        logic     cap_lt;
        logic     cap_rt;
        logic     acc_load;
        logic     head_upd;
        logic     cordic_init;
        logic     cordic_step;
        logic     step_cap;
        logic     x_upd;
        logic     y_upd;
        logic     out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic cordic_last;
    } dp_stat_t;

    // atan(2^-i) in binary angle units
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            5'd31: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

@@ src/ddodom_dpath.sv @@
// Datapath of the odometry block: config registers, shared 33x33 multiplier,
// partial product accumulator, CORDIC rotator, saturating position update.
// Depends on ddodom_pkg.
`timescale 1ns / 1ps

module ddodom_dpath
    import ddodom_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    cmd,
    output dp_stat_t                   stat,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic signed [CNT_IN_W-1:0] left_count,
    input  logic signed [CNT_IN_W-1:0] right_count,
    output logic signed [POS_W-1:0]    x_pos,
    output logic signed [POS_W-1:0]    y_pos,
    output logic [HEAD_W-1:0]          heading,
    output logic signed [POS_W-1:0]    left_travel,
    output logic signed [POS_W-1:0]    right_travel
);

    localparam int SUM_W = STEP_W + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

    // Architectural state, cleared by reset
    logic [MPP_W-1:0]          mpp_reg;
    logic [GAIN_W-1:0]         gain_reg;
    logic [CNT_IN_W-1:0]       prev_left_reg;
    logic [CNT_IN_W-1:0]       prev_right_reg;
    logic [HEAD_W-1:0]         heading_reg;
    logic signed [POS_W-1:0]   x_reg;
    logic signed [POS_W-1:0]   y_reg;

    // Working registers
    logic [CNT_IN_W-1:0]       lc_reg;
    logic [CNT_IN_W-1:0]       rc_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [POS_W-1:0]   dl_reg;
    logic signed [POS_W-1:0]   dr_reg;
    logic signed [POS_W-1:0]   lt_reg;
    logic signed [POS_W-1:0]   rt_reg;
    logic signed [CW-1:0]      cx_reg;
    logic signed [CW-1:0]      cy_reg;
    logic signed [CW-1:0]      cz_reg;
    logic                      flip_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [STEP_W-1:0]  step_reg;
    logic signed [POS_W-1:0]   x_pos_reg;
    logic signed [POS_W-1:0]   y_pos_reg;
    logic [HEAD_W-1:0]         heading_out_reg;
    logic signed [POS_W-1:0]   left_travel_reg;
    logic signed [POS_W-1:0]   right_travel_reg;

    logic [CNT_IN_W-1:0]       dlc;
    logic [CNT_IN_W-1:0]       drc;
    logic signed [POS_W:0]     diff;
    logic signed [CW-1:0]      cos_full;
    logic signed [CW-1:0]      sin_full;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [POS_W-1:0]   travel;
    logic [1:0]                quad;
    logic                      flip_next;
    logic [HEAD_W-1:0]         z_init;
    logic signed [CW-1:0]      xs;
    logic signed [CW-1:0]      ys;
    logic signed [CW-1:0]      at;
    logic signed [CW-1:0]      cx_next;
    logic signed [CW-1:0]      cy_next;
    logic signed [CW-1:0]      cz_next;
    logic signed [POS_W-1:0]   pos_sel;
    logic signed [SUM_W-1:0]   pos_sum;
    logic signed [POS_W-1:0]   pos_next;

    // Count deltas wrap modulo 2^32
    assign dlc  = lc_reg - prev_left_reg;
    assign drc  = rc_reg - prev_right_reg;
    assign diff = {dl_reg[POS_W-1], dl_reg} - {dr_reg[POS_W-1], dr_reg};

    // Fold the quadrant back out of the rotated vector
    assign cos_full = flip_reg ? -cx_reg : cx_reg;
    assign sin_full = flip_reg ? -cy_reg : cy_reg;

    // Select operands of the shared multiplier
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_DL:
            begin
                mul_a = {dlc[CNT_IN_W-1], dlc};
                mul_b = {{(MUL_W-MPP_W){1'b0}}, mpp_reg};
            end
            MUL_DR:
            begin
                mul_a = {drc[CNT_IN_W-1], drc};
                mul_b = {{(MUL_W-MPP_W){1'b0}}, mpp_reg};
            end
            MUL_LT:
            begin
                mul_a = {lc_reg[CNT_IN_W-1], lc_reg};
                mul_b = {{(MUL_W-MPP_W){1'b0}}, mpp_reg};
            end
            MUL_RT:
            begin
                mul_a = {rc_reg[CNT_IN_W-1], rc_reg};
                mul_b = {{(MUL_W-MPP_W){1'b0}}, mpp_reg};
            end
            MUL_HH:
            begin
                mul_a = {{(MUL_W-25){diff[POS_W]}}, diff[POS_W:24]};
                mul_b = {1'b0, gain_reg};
            end
            MUL_HL:
            begin
                mul_a = {{(MUL_W-24){1'b0}}, diff[23:0]};
                mul_b = {1'b0, gain_reg};
            end
            MUL_XH:
            begin
                mul_a = {{(MUL_W-24){dl_reg[POS_W-1]}}, dl_reg[POS_W-1:24]};
                mul_b = cos_full[MUL_W-1:0];
            end
            MUL_XL:
            begin
                mul_a = {{(MUL_W-24){1'b0}}, dl_reg[23:0]};
                mul_b = cos_full[MUL_W-1:0];
            end
            MUL_YH:
            begin
                mul_a = {{(MUL_W-24){dl_reg[POS_W-1]}}, dl_reg[POS_W-1:24]};
                mul_b = sin_full[MUL_W-1:0];
            end
            MUL_YL:
            begin
                mul_a = {{(MUL_W-24){1'b0}}, dl_reg[23:0]};
                mul_b = sin_full[MUL_W-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign prod_ext  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_sum   = acc_reg + prod_ext;
    // Q.24 product to Q.16, rounding toward minus infinity
    assign travel    = prod_reg[POS_W+7:8];

    // Fold heading into [-90, 90) degrees
    assign quad      = heading_reg[HEAD_W-1:HEAD_W-2];
    assign flip_next = (quad == 2'b01) || (quad == 2'b10);
    assign z_init    = flip_next ? (heading_reg - 32'h80000000) : heading_reg;

    // One CORDIC micro-rotation
    assign xs = cx_reg >>> cnt_reg;
    assign ys = cy_reg >>> cnt_reg;
    assign at = {{(CW-32){1'b0}}, atan_lut(5'(cnt_reg))};

    always_comb
    begin
        if (!cz_reg[CW-1])
        begin
            cx_next = cx_reg - ys;
            cy_next = cy_reg + xs;
            cz_next = cz_reg - at;
        end
        else
        begin
            cx_next = cx_reg + ys;
            cy_next = cy_reg - xs;
            cz_next = cz_reg + at;
        end
    end

    assign stat.cordic_last = (cnt_reg == CNT_W'(CORDIC_N - 1));

    // Saturating position add, shared by x and y
    assign pos_sel = cmd.y_upd ? y_reg : x_reg;
    assign pos_sum = {{(SUM_W-POS_W){pos_sel[POS_W-1]}}, pos_sel}
                   + {step_reg[STEP_W-1], step_reg};

    always_comb
    begin
        priority if (pos_sum > SAT_HI)
            pos_next = SAT_HI[POS_W-1:0];
        else if (pos_sum < SAT_LO)
            pos_next = SAT_LO[POS_W-1:0];
        else
            pos_next = pos_sum[POS_W-1:0];
    end

    // Update configuration and odometry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpp_reg        <= '0;
            gain_reg       <= '0;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            heading_reg    <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MPP:  mpp_reg  <= cfg_data[MPP_W-1:0];
                    CFG_GAIN: gain_reg <= cfg_data[GAIN_W-1:0];
                endcase
            end
            if (cmd.head_upd)
            begin
                heading_reg    <= heading_reg + acc_sum[63:32];
                prev_left_reg  <= lc_reg;
                prev_right_reg <= rc_reg;
            end
            if (cmd.x_upd)
                x_reg <= pos_next;
            if (cmd.y_upd)
                y_reg <= pos_next;
        end
    end

    // Advance working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            lc_reg <= left_count;
            rc_reg <= 32'd0 - right_count;
        end
        if (cmd.mul_en)
            prod_reg <= prod_next;
        if (cmd.acc_load)
            acc_reg <= prod_ext <<< 24;
        if (cmd.cap_dl)
            dl_reg <= travel;
        if (cmd.cap_dr)
            dr_reg <= travel;
        if (cmd.cap_lt)
            lt_reg <= travel;
        if (cmd.cap_rt)
            rt_reg <= travel;
        if (cmd.cordic_init)
        begin
            cx_reg   <= {{(CW-32){1'b0}}, CORDIC_GAIN};
            cy_reg   <= '0;
            cz_reg   <= {{(CW-HEAD_W){z_init[HEAD_W-1]}}, z_init};
            flip_reg <= flip_next;
            cnt_reg  <= '0;
        end
        else if (cmd.cordic_step)
        begin
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            cz_reg  <= cz_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        // floor(dl * trig / 2^30)
        if (cmd.step_cap)
            step_reg <= acc_sum[STEP_W+29:30];
        if (cmd.out_load)
        begin
            x_pos_reg        <= x_reg;
            y_pos_reg        <= y_reg;
            heading_out_reg  <= heading_reg;
            left_travel_reg  <= lt_reg;
            right_travel_reg <= rt_reg;
        end
    end

    assign x_pos        = x_pos_reg;
    assign y_pos        = y_pos_reg;
    assign heading      = heading_out_reg;
    assign left_travel  = left_travel_reg;
    assign right_travel = right_travel_reg;

endmodule

@@ src/ddodom_ctrl.sv @@
// Controller of the odometry block: sequences the multiplier passes, CORDIC
// iterations and position updates, and runs both handshakes.
// Depends on ddodom_pkg.
`timescale 1ns / 1ps

module ddodom_ctrl
    import ddodom_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_MUL_DL = 17'h00002,
        S_MUL_DR = 17'h00004,
        S_MUL_LT = 17'h00008,
        S_MUL_RT = 17'h00010,
        S_MUL_HH = 17'h00020,
        S_MUL_HL = 17'h00040,
        S_HEAD   = 17'h00080,
        S_CINIT  = 17'h00100,
        S_CITER  = 17'h00200,
        S_MUL_XH = 17'h00400,
        S_MUL_XL = 17'h00800,
        S_MUL_YH = 17'h01000,
        S_MUL_YL = 17'h02000,
        S_YSUM   = 17'h04000,
        S_YACC   = 17'h08000,
        S_OUT    = 17'h10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Sequence one transaction through the datapath
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MUL_DL;
                end
            end
            S_MUL_DL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DL;
                state_next  = S_MUL_DR;
            end
            S_MUL_DR:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DR;
                cmd.cap_dl  = 1'b1;
                state_next  = S_MUL_LT;
            end
            S_MUL_LT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LT;
                cmd.cap_dr  = 1'b1;
                state_next  = S_MUL_RT;
            end
            S_MUL_RT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RT;
                cmd.cap_lt  = 1'b1;
                state_next  = S_MUL_HH;
            end
            S_MUL_HH:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_HH;
                cmd.cap_rt  = 1'b1;
                state_next  = S_MUL_HL;
            end
            S_MUL_HL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_HL;
                cmd.acc_load = 1'b1;
                state_next   = S_HEAD;
            end
            S_HEAD:
            begin
                cmd.head_upd = 1'b1;
                state_next   = S_CINIT;
            end
            S_CINIT:
            begin
                cmd.cordic_init = 1'b1;
                state_next      = S_CITER;
            end
            S_CITER:
            begin
                cmd.cordic_step = 1'b1;
                if (stat.cordic_last)
                    state_next = S_MUL_XH;
            end
            S_MUL_XH:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_XH;
                state_next  = S_MUL_XL;
            end
            S_MUL_XL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_XL;
                cmd.acc_load = 1'b1;
                state_next   = S_MUL_YH;
            end
            S_MUL_YH:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_YH;
                cmd.step_cap = 1'b1;
                state_next   = S_MUL_YL;
            end
            S_MUL_YL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_YL;
                cmd.acc_load = 1'b1;
                cmd.x_upd    = 1'b1;
                state_next   = S_YSUM;
            end
            S_YSUM:
            begin
                cmd.step_cap = 1'b1;
                state_next   = S_YACC;
            end
            S_YACC:
            begin
                cmd.y_upd  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Set on a new result, drop once taken
    assign out_valid_next = cmd.out_load ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_MUL_DL))
        else $error("accepted transaction did not start the multiply sequence");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the finish step");

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && out_stall) |=> (state_reg == S_OUT))
        else $error("finish step left while the output register was full");

    a_cordic_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CITER && stat.cordic_last) |=> (state_reg == S_MUL_XH))
        else $error("rotation did not hand over to the position multiply");

endmodule

@@ src/differential_drive_odometry.sv @@
// Differential drive odometry: one result per accepted pair of encoder counts.
// Each pair runs the multiplier passes, the heading update, the CORDIC rotation
// and the position updates, then waits while an older result is stalled in the
// output register; a new pair is taken only in idle. The shared multiplier (10
// passes) and 16-step CORDIC set the pace. Reset zeroes config and odometry state.
`timescale 1ns / 1ps

module differential_drive_odometry
    import ddodom_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [CNT_IN_W-1:0] left_count,
    input  logic signed [CNT_IN_W-1:0] right_count,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [POS_W-1:0]    x_pos,
    output logic signed [POS_W-1:0]    y_pos,
    output logic [HEAD_W-1:0]          heading,
    output logic signed [POS_W-1:0]    left_travel,
    output logic signed [POS_W-1:0]    right_travel,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Configuration writes are always accepted and take effect on the next clock
    assign cfg_ready = 1'b1;

    ddodom_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    ddodom_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .left_count   (left_count),
        .right_count  (right_count),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .heading      (heading),
        .left_travel  (left_travel),
        .right_travel (right_travel)
    );

endmodule
